FILE: hdl/smbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMBIOS walker package
// Shared types, status codes and the cleared walk state for the SMBIOS
// structure table walker.
// ----------------------------------------------------------------------------
package smbw_pkg;

	localparam logic [7:0] END_OF_TABLE_TYPE = 8'd127;
	localparam logic [7:0] MIN_STRUCT_LENGTH = 8'd4;

	// Result status codes.
	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_END       = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [1:0] ST_MALFORMED = 2'd3;

	// Configuration register indexes.
	localparam logic REG_TARGET_TYPE = 1'b0;
	localparam logic REG_TABLE_SIZE  = 1'b1;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_FORMATTED,
		PH_STRINGS
	} smbw_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} smbw_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] struct_offset;
		logic [31:0] bytes_left;
		logic [7:0]  struct_length;
		logic [15:0] struct_handle;
	} smbw_out_t;

	typedef struct packed {
		smbw_phase_t phase;
		logic [31:0] byte_offset;
		logic [31:0] header_start;
		logic [1:0]  header_count;
		logic [7:0]  cur_type;
		logic [7:0]  cur_length;
		logic [15:0] cur_handle;
		logic [7:0]  skip_count;
		logic        prev_was_nul;
		logic        first_string;
		logic        done;
	} smbw_walk_t;

	localparam smbw_walk_t WALK_CLEAR = '{
		phase:        PH_HEADER,
		byte_offset:  32'd0,
		header_start: 32'd0,
		header_count: 2'd0,
		cur_type:     8'd0,
		cur_length:   8'd0,
		cur_handle:   16'd0,
		skip_count:   8'd0,
		prev_was_nul: 1'b0,
		first_string: 1'b1,
		done:         1'b0
	};

endpackage

FILE: hdl/smbw_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMBIOS walker step logic
// Next walk state and the optional result for one table byte.
// ----------------------------------------------------------------------------
module smbw_step import smbw_pkg::*; (
	input  smbw_walk_t  walk,
	input  smbw_in_t    item,
	input  logic [7:0]  target_type,
	input  logic [31:0] table_size,
	output smbw_walk_t  walk_next,
	output logic        emit,
	output smbw_out_t   result
);

	smbw_walk_t  cur;
	smbw_walk_t  nxt;
	logic [31:0] off;
	logic        early;
	logic [1:0]  status;

	always_comb begin
		cur    = item.restart ? WALK_CLEAR : walk;
		nxt    = cur;
		off    = cur.byte_offset;
		early  = 1'b0;
		status = ST_EXHAUSTED;
		emit   = 1'b0;

		if (!cur.done) begin
			nxt.byte_offset = off + 32'd1;
			if (off >= table_size) begin
				emit = 1'b1;
			end else begin
				case (cur.phase)
					PH_HEADER: begin
						case (cur.header_count)
							2'd0: begin
								if ((table_size - off) < 32'd4) begin
									early = 1'b1;
								end else begin
									nxt.cur_type = item.data_byte;
								end
							end
							2'd1: nxt.cur_length = item.data_byte;
							2'd2: nxt.cur_handle = {8'd0, item.data_byte};
							default: begin
								nxt.cur_handle = cur.cur_handle | {item.data_byte, 8'd0};
								if (cur.cur_type == END_OF_TABLE_TYPE) begin
									early  = 1'b1;
									status = ST_END;
								end else if (cur.cur_length < MIN_STRUCT_LENGTH) begin
									early  = 1'b1;
									status = ST_MALFORMED;
								end else if ((table_size - cur.header_start)
										< {24'd0, cur.cur_length}) begin
									early = 1'b1;
								end else if (cur.cur_type == target_type) begin
									early  = 1'b1;
									status = ST_FOUND;
								end else if (cur.cur_length == MIN_STRUCT_LENGTH) begin
									nxt.phase        = PH_STRINGS;
									nxt.prev_was_nul = 1'b0;
									nxt.first_string = 1'b1;
								end else begin
									nxt.phase      = PH_FORMATTED;
									nxt.skip_count = cur.cur_length - MIN_STRUCT_LENGTH;
								end
							end
						endcase
						if (!early) begin
							nxt.header_count = cur.header_count + 2'd1;
						end
					end
					PH_FORMATTED: begin
						nxt.skip_count = cur.skip_count - 8'd1;
						if (nxt.skip_count == 8'd0) begin
							nxt.phase        = PH_STRINGS;
							nxt.prev_was_nul = 1'b0;
							nxt.first_string = 1'b1;
						end
					end
					default: begin
						if (item.data_byte == 8'd0) begin
							if (cur.prev_was_nul && !cur.first_string) begin
								// Double NUL closes the string set.
								nxt.phase        = PH_HEADER;
								nxt.header_start = off + 32'd1;
								nxt.header_count = 2'd0;
								nxt.cur_type     = 8'd0;
								nxt.cur_length   = 8'd0;
								nxt.cur_handle   = 16'd0;
								nxt.prev_was_nul = 1'b0;
								nxt.first_string = 1'b1;
							end else begin
								nxt.prev_was_nul = 1'b1;
								nxt.first_string = 1'b0;
							end
						end else begin
							nxt.prev_was_nul = 1'b0;
						end
					end
				endcase

				// The last table byte ends the search if nothing else did.
				emit = early || (({1'b0, off} + 33'd1) >= {1'b0, table_size});
			end
		end

		if (emit) begin
			nxt.done = 1'b1;
		end
		walk_next = nxt;

		result.status        = status;
		result.struct_offset = nxt.header_start;
		result.bytes_left    = (nxt.header_start <= table_size) ?
			(table_size - nxt.header_start) : 32'd0;
		result.struct_length = nxt.cur_length;
		result.struct_handle = nxt.cur_handle;
	end

endmodule

FILE: hdl/smbios_structure_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMBIOS structure table walker
// Scans an SMBIOS structure table one byte per request and reports the first
// structure of the target type, the end-of-table marker, running out of
// table, or a malformed header length. One result per search.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+------------------------------
//  in       | input     | in_valid / in_ready  | in_data  (data_byte, restart)
//  out      | output    | out_valid / out_ready| out_data (status, offset, ...)
//  cfg      | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// Each table byte is captured in the input stage, and then the walk state and
// the result register are updated from it in a single pass, so one request is
// accepted every cycle unless a held result stalls the input stage.
// A request in the input stage advances whenever the result register is
// empty or being drained; a held result stalls only the input stage.
// Reset clears the walk state and both configuration registers; the first
// request may follow reset directly.
// ----------------------------------------------------------------------------
module smbios_structure_walker import smbw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  smbw_in_t    in_data,

	output logic        out_valid,
	input  logic        out_ready,
	output smbw_out_t   out_data,

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);

	// Configuration registers.
	logic [7:0]  target_type_q;
	logic [31:0] table_size_q;

	// Input stage: one captured request.
	logic        item_valid_s1;
	smbw_in_t    item_s1;

	// Walk state, updated once per byte.
	smbw_walk_t  walk_q;
	smbw_walk_t  walk_next;

	// Result register.
	logic        res_valid_q;
	smbw_out_t   res_q;

	logic        emit;
	smbw_out_t   result;
	logic        advance;

	// The input stage moves on unless a result is held that cannot leave.
	assign advance  = item_valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !item_valid_s1 || advance;

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_type_q <= 8'd0;
			table_size_q  <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_TYPE: target_type_q <= cfg_wdata[7:0];
				REG_TABLE_SIZE:  table_size_q  <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	smbw_step u_step (
		.walk        (walk_q),
		.item        (item_s1),
		.target_type (target_type_q),
		.table_size  (table_size_q),
		.walk_next   (walk_next),
		.emit        (emit),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= WALK_CLEAR;
		end else if (advance) begin
			walk_q <= walk_next;
		end
	end

	// A new result may land in the same cycle the old one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= result;
		end
	end

endmodule

FILE: hdl/smbw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMBIOS walker port checker
// Watches the walker's ports and flags results or stalls that cannot occur.
// ----------------------------------------------------------------------------
module smbw_checker import smbw_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input smbw_out_t out_data
);

	// A held result stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// With no result waiting the walker must take requests.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty result register");

	// A found structure has a sane length that fits in the table.
	a_found_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_FOUND |->
			out_data.struct_length >= MIN_STRUCT_LENGTH &&
			out_data.bytes_left >= {24'd0, out_data.struct_length})
		else $error("found structure with bad length");

	// Malformed is reported only for a length below the header size.
	a_malformed_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_MALFORMED |->
			out_data.struct_length < MIN_STRUCT_LENGTH)
		else $error("malformed status with a valid length");

endmodule

bind smbios_structure_walker smbw_checker u_smbw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
